// ----- hdl/scpa_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Size-class pool allocator package
// Shared constants, status and command codes, and the payload structs.
// ----------------------------------------------------------------------------
package scpa_pkg;

    // Allocator geometry. The field widths below are sized for these values.
    localparam int NUM_CLASSES       = 14;
    localparam int MIN_SIZE_LOG2     = 5;
    localparam int HEADER_BYTES      = 8;
    localparam int STACK_DEPTH_DEF   = 256;

    localparam int CLS_W  = 4;
    localparam int LG_W   = 6;
    localparam int STAT_W = 3;
    localparam int ADDR_W = 32;
    localparam int SIZE_W = 32;

    // Depth of the command queue between front and back.
    localparam int CMD_DEPTH = 4;

    // Request operations.
    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    // Result status codes.
    localparam logic [STAT_W-1:0] ST_REUSED      = 3'd0;
    localparam logic [STAT_W-1:0] ST_FRESH       = 3'd1;
    localparam logic [STAT_W-1:0] ST_LARGE_ALLOC = 3'd2;
    localparam logic [STAT_W-1:0] ST_POOLED_FREE = 3'd3;
    localparam logic [STAT_W-1:0] ST_LARGE_FREE  = 3'd4;
    localparam logic [STAT_W-1:0] ST_POOL_FULL   = 3'd5;

    // Classified command kinds handed from front to back.
    localparam logic [1:0] K_ALLOC       = 2'd0;
    localparam logic [1:0] K_ALLOC_LARGE = 2'd1;
    localparam logic [1:0] K_FREE        = 2'd2;
    localparam logic [1:0] K_FREE_LARGE  = 2'd3;

    typedef struct packed {
        logic              operation;
        logic [SIZE_W-1:0] request_size;
        logic [ADDR_W-1:0] block_address;
        logic [CLS_W-1:0]  header_class;
    } t_req;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [ADDR_W-1:0] result_address;
        logic [CLS_W-1:0]  size_class;
        logic [LG_W-1:0]   block_size_log2;
    } t_rsp;

    typedef struct packed {
        logic [1:0]        kind;
        logic [CLS_W-1:0]  size_class;
        logic [LG_W-1:0]   block_size_log2;
        logic [ADDR_W-1:0] block_address;
    } t_cmd;

endpackage

// ----- hdl/scpa_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Size-class pool allocator front end
// Registers a request, rounds its size and classifies it into a command.
// ----------------------------------------------------------------------------
module scpa_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    output logic              o_full,
    input  scpa_pkg::t_req    i_req,
    output logic              o_cmd_push,
    input  logic              i_cmd_full,
    output scpa_pkg::t_cmd    o_cmd
);

    localparam int MW = scpa_pkg::SIZE_W + 1;

    // Position of the highest set bit.
    function automatic logic [scpa_pkg::LG_W-1:0] floor_log2(input logic [MW-1:0] v);
        logic [scpa_pkg::LG_W-1:0] p;
        p = '0;
        for (int i = 0; i < MW; i++) begin
            if (v[i]) begin
                p = scpa_pkg::LG_W'(i);
            end
        end
        return p;
    endfunction

    logic                           r_valid;
    logic                           r_op;
    logic [MW-1:0]                  r_m;
    logic [scpa_pkg::ADDR_W-1:0]    r_addr;
    logic [scpa_pkg::CLS_W-1:0]     r_tag;

    logic                           w_accept;
    logic                           w_drain;
    logic [MW-1:0]                  w_n;
    logic [MW-1:0]                  w_n_min;
    logic [scpa_pkg::LG_W-1:0]      w_lg;
    logic [scpa_pkg::LG_W-1:0]      w_cls_raw;

    assign o_full   = r_valid && i_cmd_full;
    assign w_accept = i_push && !o_full;
    assign w_drain  = r_valid && !i_cmd_full;

    // Stage A: header added and raised to the minimum block; m = n - 1.
    assign w_n     = MW'(i_req.request_size) + MW'(scpa_pkg::HEADER_BYTES);
    assign w_n_min = (w_n < MW'(1) << scpa_pkg::MIN_SIZE_LOG2)
                   ? (MW'(1) << scpa_pkg::MIN_SIZE_LOG2) : w_n;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_accept) begin
            r_valid <= 1'b1;
        end else if (w_drain) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_op   <= i_req.operation;
            r_m    <= w_n_min - MW'(1);
            r_addr <= i_req.block_address;
            r_tag  <= i_req.header_class;
        end
    end

    // Stage B: ceiling log2 and class selection.
    assign w_lg      = floor_log2(r_m) + scpa_pkg::LG_W'(1);
    assign w_cls_raw = w_lg - scpa_pkg::LG_W'(scpa_pkg::MIN_SIZE_LOG2);

    assign o_cmd_push = w_drain;

    always_comb begin
        o_cmd.block_address = r_addr;
        if (r_op == scpa_pkg::OP_ALLOC) begin
            o_cmd.block_size_log2 = w_lg;
            if (w_cls_raw >= scpa_pkg::LG_W'(scpa_pkg::NUM_CLASSES)) begin
                o_cmd.kind       = scpa_pkg::K_ALLOC_LARGE;
                o_cmd.size_class = scpa_pkg::CLS_W'(scpa_pkg::NUM_CLASSES);
            end else begin
                o_cmd.kind       = scpa_pkg::K_ALLOC;
                o_cmd.size_class = w_cls_raw[scpa_pkg::CLS_W-1:0];
            end
        end else begin
            if (r_tag >= scpa_pkg::CLS_W'(scpa_pkg::NUM_CLASSES)) begin
                o_cmd.kind            = scpa_pkg::K_FREE_LARGE;
                o_cmd.size_class      = scpa_pkg::CLS_W'(scpa_pkg::NUM_CLASSES);
                o_cmd.block_size_log2 = '0;
            end else begin
                o_cmd.kind            = scpa_pkg::K_FREE;
                o_cmd.size_class      = r_tag;
                o_cmd.block_size_log2 = scpa_pkg::LG_W'(scpa_pkg::MIN_SIZE_LOG2)
                                      + scpa_pkg::LG_W'(r_tag);
            end
        end
    end

endmodule

// ----- hdl/scpa_cmd_fifo.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Size-class pool allocator command queue
// Small register queue that decouples the front end from the pool back end.
// ----------------------------------------------------------------------------
module scpa_cmd_fifo (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  scpa_pkg::t_cmd    i_cmd,
    output logic              o_full,
    input  logic              i_pop,
    output scpa_pkg::t_cmd    o_cmd,
    output logic              o_empty
);

    localparam int PW = $clog2(scpa_pkg::CMD_DEPTH);

    scpa_pkg::t_cmd r_buf [scpa_pkg::CMD_DEPTH];
    logic [PW:0]    r_wr;
    logic [PW:0]    r_rd;

    assign o_empty = (r_wr == r_rd);
    assign o_full  = (r_wr[PW] != r_rd[PW]) && (r_wr[PW-1:0] == r_rd[PW-1:0]);
    assign o_cmd   = r_buf[r_rd[PW-1:0]];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr <= '0;
            r_rd <= '0;
        end else begin
            if (i_push && !o_full) begin
                r_wr <= r_wr + (PW+1)'(1);
            end
            if (i_pop && !o_empty) begin
                r_rd <= r_rd + (PW+1)'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push && !o_full) begin
            r_buf[r_wr[PW-1:0]] <= i_cmd;
        end
    end

endmodule

// ----- hdl/scpa_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Size-class pool allocator back end
// Per-class stack counts, the free stack memory and the result register.
// ----------------------------------------------------------------------------
module scpa_back #(
    parameter int STACK_DEPTH = scpa_pkg::STACK_DEPTH_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  scpa_pkg::t_cmd    i_cmd,
    input  logic              i_cmd_empty,
    output logic              o_cmd_pop,
    output logic              o_empty,
    input  logic              i_pop,
    output scpa_pkg::t_rsp    o_rsp
);

    localparam int CNT_W     = $clog2(STACK_DEPTH + 1);
    localparam int PTR_W     = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int MEM_DEPTH = scpa_pkg::NUM_CLASSES * STACK_DEPTH;
    localparam int AW        = $clog2(MEM_DEPTH);
    localparam int IDX_W     = $clog2(scpa_pkg::NUM_CLASSES);

    typedef struct packed {
        logic [scpa_pkg::STAT_W-1:0] status;
        logic [scpa_pkg::CLS_W-1:0]  size_class;
        logic [scpa_pkg::LG_W-1:0]   block_size_log2;
    } t_s2;

    logic [CNT_W-1:0]             r_cnt [scpa_pkg::NUM_CLASSES];
    logic [scpa_pkg::ADDR_W-1:0]  r_mem [MEM_DEPTH];
    logic [scpa_pkg::ADDR_W-1:0]  r_rdata;
    logic                         r_s2_valid;
    t_s2                          r_s2;

    logic                         w_fire;
    logic                         w_pooled;
    logic [IDX_W-1:0]             w_idx;
    logic [CNT_W-1:0]             w_cnt;
    logic                         w_we;
    logic                         w_re;
    logic [PTR_W-1:0]             w_ptr;
    logic [AW-1:0]                w_maddr;
    logic [scpa_pkg::STAT_W-1:0]  w_status;

    assign w_fire    = !i_cmd_empty && (!r_s2_valid || i_pop);
    assign o_cmd_pop = w_fire;

    assign w_pooled = (i_cmd.kind == scpa_pkg::K_ALLOC) || (i_cmd.kind == scpa_pkg::K_FREE);
    assign w_idx    = w_pooled ? i_cmd.size_class[IDX_W-1:0] : '0;
    assign w_cnt    = r_cnt[w_idx];

    always_comb begin
        w_re     = 1'b0;
        w_we     = 1'b0;
        w_ptr    = w_cnt[PTR_W-1:0];
        w_status = scpa_pkg::ST_LARGE_FREE;
        unique case (i_cmd.kind)
            scpa_pkg::K_ALLOC: begin
                if (w_cnt != '0) begin
                    w_re     = w_fire;
                    w_ptr    = PTR_W'(w_cnt - CNT_W'(1));
                    w_status = scpa_pkg::ST_REUSED;
                end else begin
                    w_status = scpa_pkg::ST_FRESH;
                end
            end
            scpa_pkg::K_FREE: begin
                if (w_cnt == CNT_W'(STACK_DEPTH)) begin
                    w_status = scpa_pkg::ST_POOL_FULL;
                end else begin
                    w_we     = w_fire;
                    w_status = scpa_pkg::ST_POOLED_FREE;
                end
            end
            scpa_pkg::K_ALLOC_LARGE: begin
                w_status = scpa_pkg::ST_LARGE_ALLOC;
            end
            default: begin
                w_status = scpa_pkg::ST_LARGE_FREE;
            end
        endcase
    end

    assign w_maddr = AW'(AW'(w_idx) * AW'(STACK_DEPTH) + AW'(w_ptr));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < scpa_pkg::NUM_CLASSES; i++) begin
                r_cnt[i] <= '0;
            end
        end else if (w_re) begin
            r_cnt[w_idx] <= w_cnt - CNT_W'(1);
        end else if (w_we) begin
            r_cnt[w_idx] <= w_cnt + CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_maddr] <= i_cmd.block_address;
        end
        if (w_re) begin
            r_rdata <= r_mem[w_maddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else if (w_fire) begin
            r_s2_valid <= 1'b1;
        end else if (i_pop) begin
            r_s2_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_s2.status          <= w_status;
            r_s2.size_class      <= i_cmd.size_class;
            r_s2.block_size_log2 <= i_cmd.block_size_log2;
        end
    end

    assign o_empty                = !r_s2_valid;
    assign o_rsp.status           = r_s2.status;
    assign o_rsp.result_address   = (r_s2.status == scpa_pkg::ST_REUSED) ? r_rdata : '0;
    assign o_rsp.size_class       = r_s2.size_class;
    assign o_rsp.block_size_log2  = r_s2.block_size_log2;

`ifndef NO_ASSERTIONS
    a_no_rw_same_cycle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_we && w_re))
        else $error("stack memory read and written in the same cycle");

    a_count_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_fire |-> (w_cnt <= CNT_W'(STACK_DEPTH)))
        else $error("stack count above stack depth");

    a_pop_gives_reuse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_re |=> (r_s2_valid && r_s2.status == scpa_pkg::ST_REUSED))
        else $error("stack pop not followed by a reuse result");

    a_push_counts_up: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_we |=> (r_cnt[$past(w_idx)] == $past(w_cnt) + CNT_W'(1)))
        else $error("stack push did not advance the count");
`endif

endmodule

// ----- hdl/size_class_pool_allocator.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Size-class pool allocator
// Allocate and free requests against per-class bounded free stacks.
// ----------------------------------------------------------------------------
// Each request transfer gives exactly one result transfer, in request order.
// The allocator sustains one request per clock cycle when results are popped
// as fast as they appear. Between a request transfer and its result lie the
// front register, the command queue and the result register: the transfer
// loads the front register, the classified command is then written into the
// command queue, and the back end then does the stack push or the registered
// read of the free stack memory and loads the result register. Both sides
// behave as queues: push a request while full is low, and pop a result while
// empty is low. The stack memory needs no clearing after reset, so requests
// are taken as soon as reset is released.
// ----------------------------------------------------------------------------
module size_class_pool_allocator #(
    parameter int STACK_DEPTH = scpa_pkg::STACK_DEPTH_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    output logic              o_full,
    input  scpa_pkg::t_req    i_req,
    output logic              o_empty,
    input  logic              i_pop,
    output scpa_pkg::t_rsp    o_rsp
);

    // Classified commands travel from the front end to the back end through a
    // short queue, so a stalled result consumer does not stall the request
    // side until that queue has filled.
    scpa_pkg::t_cmd w_front_cmd;
    scpa_pkg::t_cmd w_back_cmd;
    logic           w_cmd_push;
    logic           w_cmd_full;
    logic           w_cmd_pop;
    logic           w_cmd_empty;

    // The front end rounds the size up to a power of two and picks the class.
    scpa_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (i_push),
        .o_full     (o_full),
        .i_req      (i_req),
        .o_cmd_push (w_cmd_push),
        .i_cmd_full (w_cmd_full),
        .o_cmd      (w_front_cmd)
    );

    scpa_cmd_fifo u_cmd_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_cmd_push),
        .i_cmd   (w_front_cmd),
        .o_full  (w_cmd_full),
        .i_pop   (w_cmd_pop),
        .o_cmd   (w_back_cmd),
        .o_empty (w_cmd_empty)
    );

    // The back end does the single push or pop on the class stack and holds
    // the finished result until it is transferred out.
    scpa_back #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_back_cmd),
        .i_cmd_empty (w_cmd_empty),
        .o_cmd_pop   (w_cmd_pop),
        .o_empty     (o_empty),
        .i_pop       (i_pop),
        .o_rsp       (o_rsp)
    );

endmodule
